FILE: hw/rtl/cbsf_pkg.sv
package cbsf_pkg;

  // Frame limit ceiling; max_frame_len above this is clamped.
  localparam logic [12:0] MAX_FRAME_BYTES = 13'd4096;
  localparam logic [7:0]  CRC_POLY        = 8'h8C;

  // Result slots per transaction: start, escape, payload, escape, crc, end.
  localparam int NUM_SLOTS = 6;

  localparam logic [7:0]  START_MARKER_RST  = 8'd126;
  localparam logic [7:0]  END_MARKER_RST    = 8'd127;
  localparam logic [7:0]  ESCAPE_MARKER_RST = 8'd125;
  localparam logic [7:0]  ESCAPE_MASK_RST   = 8'd32;
  localparam logic [12:0] MAX_FRAME_LEN_RST = 13'd256;

  typedef enum logic [2:0] {
    REG_START_MARKER  = 3'd0,
    REG_END_MARKER    = 3'd1,
    REG_ESCAPE_MARKER = 3'd2,
    REG_ESCAPE_MASK   = 3'd3,
    REG_MAX_FRAME_LEN = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last_in_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        run_last;
    logic        frame_done;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [7:0]  escape_marker;
    logic [7:0]  escape_mask;
    logic [12:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  crc;
    logic [12:0] count;
    logic        in_frame;
    logic        dropping;
  } frame_state_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        done;
    logic        ovf;
  } slot_t;

  // Reflected CRC-8, one byte, bit at a time.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/cbsf_encoder.sv
// Expands one input byte into up to six fixed result slots and computes
// the next frame state. Pure combinational.
module cbsf_encoder (
  input  cbsf_pkg::in_item_t                        item,
  input  cbsf_pkg::cfg_t                            cfg,
  input  cbsf_pkg::frame_state_t                    state,
  output logic [cbsf_pkg::NUM_SLOTS-1:0]            mask,
  output cbsf_pkg::slot_t [cbsf_pkg::NUM_SLOTS-1:0] slots,
  output cbsf_pkg::frame_state_t                    state_next
);

  logic [7:0]  b;
  logic        last;
  logic [7:0]  crc_new;
  logic        b_esc;
  logic        c_esc;
  logic [12:0] limit;
  logic [12:0] base;
  logic [12:0] diff;
  logic [2:0]  room;
  logic [2:0]  total;
  logic [2:0]  ord;
  logic        ok;
  logic [cbsf_pkg::NUM_SLOTS-1:0] need;
  cbsf_pkg::slot_t [cbsf_pkg::NUM_SLOTS-1:0] cand;

  assign b    = item.payload_byte;
  assign last = item.last_in_packet;

  assign crc_new = cbsf_pkg::crc8_update(state.in_frame ? state.crc : 8'd0, b);

  assign b_esc = (b == cfg.start_marker) || (b == cfg.end_marker) ||
                 (b == cfg.escape_marker);
  assign c_esc = (crc_new == cfg.start_marker) || (crc_new == cfg.end_marker) ||
                 (crc_new == cfg.escape_marker);

  assign limit = (cfg.max_frame_len > cbsf_pkg::MAX_FRAME_BYTES) ?
                 cbsf_pkg::MAX_FRAME_BYTES : cfg.max_frame_len;
  // A fresh frame already holds its start marker.
  assign base  = state.in_frame ? state.count : 13'd1;
  assign diff  = limit - base;

  always_comb begin
    if (limit <= base) begin
      room = 3'd0;
    end else if (diff >= 13'd5) begin
      room = 3'd5;
    end else begin
      room = diff[2:0];
    end
  end

  always_comb begin
    need[0] = !state.in_frame;
    need[1] = b_esc;
    need[2] = 1'b1;
    need[3] = last && c_esc;
    need[4] = last;
    need[5] = last;

    cand[0] = '{data: cfg.start_marker, done: 1'b0, ovf: 1'b0};
    cand[1] = '{data: cfg.escape_marker, done: 1'b0, ovf: 1'b0};
    cand[2] = '{data: b_esc ? (b ^ cfg.escape_mask) : b, done: 1'b0, ovf: 1'b0};
    cand[3] = '{data: cfg.escape_marker, done: 1'b0, ovf: 1'b0};
    cand[4] = '{data: c_esc ? (crc_new ^ cfg.escape_mask) : crc_new,
                done: 1'b0, ovf: 1'b0};
    cand[5] = '{data: cfg.end_marker, done: 1'b1, ovf: 1'b0};
  end

  // Checked slots: those within room go out, the first one past it becomes
  // the overflow result, later ones vanish.
  always_comb begin
    mask     = '0;
    slots    = cand;
    ord      = 3'd0;
    mask[0]  = need[0];
    for (int j = 1; j < cbsf_pkg::NUM_SLOTS; j++) begin
      if (need[j]) begin
        if (ord < room) begin
          mask[j] = 1'b1;
        end else if (ord == room) begin
          mask[j]  = 1'b1;
          slots[j] = '{data: 8'd0, done: 1'b1, ovf: 1'b1};
        end
        ord = ord + 3'd1;
      end
    end
    total = ord;
    if (state.dropping) begin
      mask = '0;
    end
  end

  assign ok = (total <= room);

  always_comb begin
    state_next = state;
    if (state.dropping) begin
      state_next.dropping = !last;
    end else if (!ok) begin
      state_next = '{crc: 8'd0, count: 13'd0, in_frame: 1'b0, dropping: !last};
    end else if (last) begin
      state_next = '{crc: 8'd0, count: 13'd0, in_frame: 1'b0, dropping: 1'b0};
    end else begin
      state_next.crc      = crc_new;
      state_next.count    = base + {10'd0, total};
      state_next.in_frame = 1'b1;
    end
  end

endmodule

FILE: hw/rtl/crc8_byte_stuffing_framer.sv
// Byte-stuffing framer with a reflected CRC-8 trailer (poly 0x8C, init 0).
// Each payload byte transaction on the item channel yields up to six result
// transactions: a start marker before the first byte of a packet, the byte
// (escaped as escape_marker, byte ^ escape_mask when it matches any marker),
// and on the last byte the escaped CRC and the end marker. Output bytes per
// frame, markers included, are held to max_frame_len (capped at 4096); a
// byte past the limit is replaced by one overflow result (out_byte 0,
// frame_done and overflow set) and the rest of the packet produces nothing.
// Rate: one item per cycle while each item yields at most one result and the
// result channel does not stall; an item with more results holds the result
// channel until the single result port has drained them from the slot buffer,
// plus any result stall. A discarded item yields no result. An accepted item
// goes through the input register, then the slot buffer, to its first result.
// Write configuration only while no item is in flight; cfg_ready is always
// high.
module crc8_byte_stuffing_framer (
  input  logic                clk,
  input  logic                rst,
  // item channel
  input  logic                item_valid,
  output logic                item_stall,
  input  cbsf_pkg::in_item_t  item,
  // result channel
  output logic                result_valid,
  input  logic                result_stall,
  output cbsf_pkg::out_item_t result,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [12:0]         cfg_data
);

  cbsf_pkg::cfg_t         cfg;
  cbsf_pkg::frame_state_t state;
  cbsf_pkg::frame_state_t state_next;

  // Input register.
  logic                   ireg_valid;
  cbsf_pkg::in_item_t     ireg;

  // Result slot buffer: a set mask bit is a result still to send, sent in
  // ascending slot order.
  logic [cbsf_pkg::NUM_SLOTS-1:0]            buf_mask;
  cbsf_pkg::slot_t [cbsf_pkg::NUM_SLOTS-1:0] buf_slots;

  logic [cbsf_pkg::NUM_SLOTS-1:0]            enc_mask;
  cbsf_pkg::slot_t [cbsf_pkg::NUM_SLOTS-1:0] enc_slots;

  logic [cbsf_pkg::NUM_SLOTS-1:0] low;
  logic [cbsf_pkg::NUM_SLOTS-1:0] rest;
  cbsf_pkg::slot_t                sel;
  logic                           item_fire;
  logic                           result_fire;
  logic                           load;

  cbsf_encoder u_encoder (
    .item       (ireg),
    .cfg        (cfg),
    .state      (state),
    .mask       (enc_mask),
    .slots      (enc_slots),
    .state_next (state_next)
  );

  // Pick the lowest pending slot.
  assign low  = buf_mask & (~buf_mask + 1'b1);
  assign rest = buf_mask & ~low;

  always_comb begin
    sel = '0;
    for (int j = 0; j < cbsf_pkg::NUM_SLOTS; j++) begin
      if (low[j]) begin
        sel = buf_slots[j];
      end
    end
  end

  assign result_valid      = |buf_mask;
  assign result.out_byte   = sel.data;
  assign result.run_last   = (rest == '0);
  assign result.frame_done = sel.done;
  assign result.overflow   = sel.ovf;

  assign result_fire = result_valid && !result_stall;
  // Buffer takes the next item once its last result leaves (or it is empty).
  assign load        = ireg_valid && (!result_valid || (result_fire && rest == '0));
  assign item_stall  = ireg_valid && !load;
  assign item_fire   = item_valid && !item_stall;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (item_fire) begin
      ireg_valid <= 1'b1;
    end else if (load) begin
      ireg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      ireg <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_mask <= '0;
    end else if (load) begin
      buf_mask <= enc_mask;
    end else if (result_fire) begin
      buf_mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_slots <= enc_slots;
    end
  end

  // Frame state advances when an item's results enter the buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{crc: 8'd0, count: 13'd0, in_frame: 1'b0, dropping: 1'b0};
    end else if (load) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker  <= cbsf_pkg::START_MARKER_RST;
      cfg.end_marker    <= cbsf_pkg::END_MARKER_RST;
      cfg.escape_marker <= cbsf_pkg::ESCAPE_MARKER_RST;
      cfg.escape_mask   <= cbsf_pkg::ESCAPE_MASK_RST;
      cfg.max_frame_len <= cbsf_pkg::MAX_FRAME_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cbsf_pkg::cfg_reg_t'(cfg_index))
        cbsf_pkg::REG_START_MARKER:  cfg.start_marker  <= cfg_data[7:0];
        cbsf_pkg::REG_END_MARKER:    cfg.end_marker    <= cfg_data[7:0];
        cbsf_pkg::REG_ESCAPE_MARKER: cfg.escape_marker <= cfg_data[7:0];
        cbsf_pkg::REG_ESCAPE_MASK:   cfg.escape_mask   <= cfg_data[7:0];
        cbsf_pkg::REG_MAX_FRAME_LEN: cfg.max_frame_len <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: tb/sv/crc8_byte_stuffing_framer_tb.sv
// Scoreboard: mirrors the framer state and holds the framed bytes still due.
class frame_checker;
  logic [7:0]  start_mk;
  logic [7:0]  end_mk;
  logic [7:0]  esc_mk;
  logic [7:0]  esc_mask;
  logic [12:0] len_cap;
  logic [7:0]  crc;
  logic [12:0] nbytes;
  bit          open_frame;
  bit          discarding;
  cbsf_pkg::out_item_t due[$];
  cbsf_pkg::out_item_t burst[$];
  int          errors;
  int          n_items;
  int          n_results;
  int          n_overflows;
  int          n_frames;

  function new();
    start_mk   = cbsf_pkg::START_MARKER_RST;
    end_mk     = cbsf_pkg::END_MARKER_RST;
    esc_mk     = cbsf_pkg::ESCAPE_MARKER_RST;
    esc_mask   = cbsf_pkg::ESCAPE_MASK_RST;
    len_cap    = cbsf_pkg::MAX_FRAME_LEN_RST;
    crc        = 8'h00;
    nbytes     = '0;
    open_frame = 1'b0;
    discarding = 1'b0;
  endfunction

  function void write_reg(cbsf_pkg::cfg_reg_t idx, logic [12:0] data);
    case (idx)
      cbsf_pkg::REG_START_MARKER:  start_mk = data[7:0];
      cbsf_pkg::REG_END_MARKER:    end_mk   = data[7:0];
      cbsf_pkg::REG_ESCAPE_MARKER: esc_mk   = data[7:0];
      cbsf_pkg::REG_ESCAPE_MASK:   esc_mask = data[7:0];
      cbsf_pkg::REG_MAX_FRAME_LEN: len_cap  = data;
      default: ;
    endcase
  endfunction

  // reflected CRC-8, LSB first
  function logic [7:0] crc_after(logic [7:0] c, logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    repeat (8) r = r[0] ? ((r >> 1) ^ cbsf_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function bit put_counted(logic [7:0] b, bit done);
    logic [12:0] cap;
    cbsf_pkg::out_item_t o;
    cap = (len_cap > cbsf_pkg::MAX_FRAME_BYTES) ? cbsf_pkg::MAX_FRAME_BYTES : len_cap;
    if (nbytes >= cap) return 1'b0;
    o = '{out_byte: b, run_last: 1'b0, frame_done: done, overflow: 1'b0};
    burst.push_back(o);
    nbytes++;
    return 1'b1;
  endfunction

  function bit put_escaped(logic [7:0] b);
    if (b == start_mk || b == end_mk || b == esc_mk) begin
      if (!put_counted(esc_mk, 1'b0)) return 1'b0;
      return put_counted(b ^ esc_mask, 1'b0);
    end
    return put_counted(b, 1'b0);
  endfunction

  function void close_frame();
    crc        = 8'h00;
    nbytes     = '0;
    open_frame = 1'b0;
  endfunction

  // Queue the framed bytes that one accepted payload transaction produces.
  function void predict_frame_bytes(cbsf_pkg::in_item_t it);
    bit        ok;
    cbsf_pkg::out_item_t o;
    burst.delete();
    n_items++;
    if (discarding) begin
      if (it.last_in_packet) discarding = 1'b0;
      return;
    end
    if (!open_frame) begin
      open_frame = 1'b1;
      crc        = 8'h00;
      o = '{out_byte: start_mk, run_last: 1'b0, frame_done: 1'b0, overflow: 1'b0};
      burst.push_back(o);
      nbytes = 13'd1;
    end
    crc = crc_after(crc, it.payload_byte);
    ok  = put_escaped(it.payload_byte);
    if (ok && it.last_in_packet) begin
      ok = put_escaped(crc);
      if (ok) ok = put_counted(end_mk, 1'b1);
      if (ok) close_frame();
    end
    if (!ok) begin
      o = '{out_byte: 8'h00, run_last: 1'b0, frame_done: 1'b1, overflow: 1'b1};
      burst.push_back(o);
      close_frame();
      discarding = !it.last_in_packet;
    end
    if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
    foreach (burst[i]) due.push_back(burst[i]);
  endfunction

  function int pending();
    return due.size();
  endfunction

  task report(string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  task check_result(cbsf_pkg::out_item_t got);
    cbsf_pkg::out_item_t want;
    n_results++;
    if (due.size() == 0) begin
      report($sformatf("result %0d (byte %02h) with nothing expected", n_results,
                       got.out_byte));
      return;
    end
    want = due.pop_front();
    if (want.overflow) n_overflows++;
    else if (want.frame_done) n_frames++;
    if (got.out_byte !== want.out_byte)
      report($sformatf("result %0d out_byte %02h, want %02h", n_results,
                       got.out_byte, want.out_byte));
    if (got.run_last !== want.run_last)
      report($sformatf("result %0d run_last %b, want %b", n_results,
                       got.run_last, want.run_last));
    if (got.frame_done !== want.frame_done)
      report($sformatf("result %0d frame_done %b, want %b", n_results,
                       got.frame_done, want.frame_done));
    if (got.overflow !== want.overflow)
      report($sformatf("result %0d overflow %b, want %b", n_results,
                       got.overflow, want.overflow));
  endtask
endclass

module crc8_byte_stuffing_framer_tb;
  // quiet cycles after the last result before touching config or ending;
  // covers the path through the input register and slot buffer plus items that make no result at all
  localparam int SETTLE_CYCLES   = 8;
  // cycles with no transaction on any channel before giving up
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 60;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  cbsf_pkg::in_item_t  item;
  logic        result_valid;
  logic        result_stall = 1'b0;
  cbsf_pkg::out_item_t result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  frame_checker sb = new();

  // current marker values, used to bias payload toward escapes
  logic [7:0] markers [3];
  int gap_max;            // longest sender gap between bursts, 0 = no gaps
  int burst_left;         // transactions left in the current sender burst
  int stall_pct;          // receiver stall probability for this stretch
  int stall_stretch_left;
  int idle_cycles;

  crc8_byte_stuffing_framer uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver backpressure: stretches of random length, each with its own
  // stall rate; about two stretches in five never stall at all.
  always @(negedge clk) begin
    if (stall_stretch_left == 0) begin
      case ($urandom_range(4, 0))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 25;
        3:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      stall_stretch_left = $urandom_range(80, 20);
    end
    stall_stretch_left--;
    result_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
  end

  // Result monitor: every accepted result goes against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // Watchdog: any transaction on any channel resets the count.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One payload transaction. Called at a falling edge, returns at one.
  // Valid stays high across a burst; gaps drop it for a random count.
  task automatic send_item(input logic [7:0] b, input bit last);
    cbsf_pkg::in_item_t it;
    it.payload_byte   = b;
    it.last_in_packet = last;
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(gap_max, 1)) @(negedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sb.predict_frame_bytes(it);
    @(negedge clk);
  endtask

  // Random packet content, about a third of the bytes hitting a marker.
  task automatic send_packet(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99, 0) < 35) b = markers[$urandom_range(2, 0)];
      else b = 8'($urandom_range(255, 0));
      send_item(b, i == len - 1);
    end
  endtask

  // Register write; valid is left high so back-to-back writes stay clean.
  task automatic cfg_write(input cbsf_pkg::cfg_reg_t idx, input logic [12:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] s, e, x, m, input logic [12:0] lim);
    cfg_write(cbsf_pkg::REG_START_MARKER, {5'd0, s});
    cfg_write(cbsf_pkg::REG_END_MARKER, {5'd0, e});
    cfg_write(cbsf_pkg::REG_ESCAPE_MARKER, {5'd0, x});
    cfg_write(cbsf_pkg::REG_ESCAPE_MASK, {5'd0, m});
    cfg_write(cbsf_pkg::REG_MAX_FRAME_LEN, lim);
    cfg_valid  <= 1'b0;
    markers[0] = s;
    markers[1] = e;
    markers[2] = x;
  endtask

  // Sender holds off until every expected result is in, then lets the
  // block go quiet (dropped bytes give no result to wait on).
  task automatic settle();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [7:0] pick;
    int         count;
    int         len;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rst        = 1'b1;
    gap_max    = 2;
    burst_left = 0;
    markers[0] = cbsf_pkg::START_MARKER_RST;
    markers[1] = cbsf_pkg::END_MARKER_RST;
    markers[2] = cbsf_pkg::ESCAPE_MARKER_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed, reset settings ---
    // one-byte packet, zero payload
    send_item(8'h00, 1'b1);
    // every marker in the payload, plus the top value
    send_item(8'h7E, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h7D, 1'b0);
    send_item(8'hFF, 1'b1);
    // single-byte packets whose CRC lands on each marker, so the trailer
    // itself has to be escaped
    for (int k = 0; k < 3; k++) begin
      pick = 8'h00;
      for (int v = 0; v < 256; v++)
        if (sb.crc_after(8'h00, v[7:0]) == markers[k]) pick = v[7:0];
      send_item(pick, 1'b1);
    end
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b1);

    // --- directed, smallest frame limit ---
    settle();
    apply_settings(8'd126, 8'd127, 8'd125, 8'd32, 13'd2);
    send_item(8'h11, 1'b1);   // no room for the CRC
    send_item(8'h7E, 1'b1);   // escape fits, escaped byte does not
    send_item(8'h01, 1'b0);   // fills the frame
    send_item(8'h02, 1'b0);   // overflows mid-packet, starts discarding
    send_item(8'h03, 1'b1);   // swallowed, ends the discard
    send_item(8'h44, 1'b1);   // next packet opens a fresh frame

    // --- directed, start equals escape, full mask, largest limit ---
    settle();
    apply_settings(8'h00, 8'hFF, 8'h00, 8'hFF, 13'd4096);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'h00, 1'b1);

    // --- directed, all three markers equal, zero mask ---
    settle();
    apply_settings(8'h5A, 8'h5A, 8'h5A, 8'h00, 13'd5);
    send_item(8'h5A, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'h10, 1'b1);

    // --- random packets under a series of settings ---
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          gap_max = 0;
          apply_settings(cbsf_pkg::START_MARKER_RST, cbsf_pkg::END_MARKER_RST,
                         cbsf_pkg::ESCAPE_MARKER_RST, cbsf_pkg::ESCAPE_MASK_RST,
                         cbsf_pkg::MAX_FRAME_LEN_RST);
        end
        1: begin
          gap_max = 6;
          apply_settings(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                         8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                         13'd4096);
        end
        2: begin
          gap_max = 3;
          apply_settings(8'hFF, 8'h00, 8'hFF, 8'h00, 13'd2);
        end
        3: begin
          gap_max = 2;
          apply_settings(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                         8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                         13'($urandom_range(24, 2)));
        end
        4: begin
          // markers crowded together, often equal
          gap_max = 8;
          apply_settings(8'($urandom_range(3, 0)), 8'($urandom_range(3, 0)),
                         8'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
                         13'($urandom_range(60, 6)));
        end
        default: begin
          gap_max = 1;
          apply_settings(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                         8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                         13'($urandom_range(4096, 2)));
        end
      endcase
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        len = ($urandom_range(9, 0) < 8) ? $urandom_range(8, 1) : $urandom_range(40, 9);
        send_packet(len);
        count += len;
      end
    end

    settle();
    $display("framer run: %0d payload bytes in, %0d framed bytes checked,",
             sb.n_items, sb.n_results);
    $display("  %0d frames closed, %0d overflow aborts; covered marker and trailer",
             sb.n_frames, sb.n_overflows);
    $display("  escaping, equal markers, limits 2..4096, drop after overflow");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/cbsf_pkg.sv
hw/rtl/cbsf_encoder.sv
hw/rtl/crc8_byte_stuffing_framer.sv
tb/sv/crc8_byte_stuffing_framer_tb.sv
